// File: design/mtb_pkg.sv
// shared types and constants for the bounded mersenne twister generator
`timescale 1ns / 1ps
package mtb_pkg;
  localparam int unsigned N = 624;
  localparam int unsigned M = 397;
  localparam int unsigned IDX_W = 10;
  localparam logic [31:0] MATRIX = 32'h9908b0df;
  localparam logic [31:0] INIT_MULT = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C = 32'hefc60000;
  localparam logic [IDX_W-1:0] IDX_DUE = 10'd624;
  localparam logic [IDX_W-1:0] IDX_NEVER = 10'd625;

  localparam logic [0:0] REG_SEED = 1'b0;
  localparam logic [0:0] REG_ENABLE = 1'b1;

  localparam logic OP_BOUNDED = 1'b0;
  localparam logic OP_RAW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_MUL,
    ST_INIT_WR,
    ST_TW_RD0,
    ST_TW_RD1,
    ST_TW_RD2,
    ST_TW_WR,
    ST_RD,
    ST_TEMPER,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

// File: design/mtb_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface mtb_req_if;
  logic valid;
  logic ready;
  logic op;
  logic [31:0] range_bound;
  modport source (output valid, op, range_bound, input ready);
  modport sink (input valid, op, range_bound, output ready);
endinterface

interface mtb_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface mtb_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/mtb_divider.sv
// restoring divider, one quotient bit per cycle, remainder only
`timescale 1ns / 1ps
module mtb_divider
  import mtb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0] cnt;
  logic busy;
  logic done;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      // rem:quo shift, subtract when it fits
      if (!trial[32]) begin
        rem <= trial[31:0];
      end else begin
        rem <= {rem[30:0], quo[31]};
      end
      quo <= {quo[30:0], 1'b0};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem = rem;
endmodule

// File: design/mersenne_twister_bounded_rng_top.sv
// top level of the bounded mersenne twister generator
`timescale 1ns / 1ps
// MT19937 word generator with a bounded draw.
// channels: req (op, range_bound) in, rsp (value) out, cfg writes of
// register 0 = seed and register 1 = draw_enable.
// each request gives exactly one response. a raw draw from a ready word
// is read and tempered; a bounded draw then passes through the serial
// remainder unit. a bounded draw that is disabled or has a bound of 1 or
// less answers zero without touching the state.
// every 624 words the state is twisted in place, each word through the
// single-port state memory with three reads and one write. seeding fills
// the memory word by word and runs on the first advancing draw after
// reset or after a seed write.
// after reset the generator is unseeded and uses seed 5489.
// the result is held in an output register until it is taken; a stalled
// receiver holds the block, which takes the next request only after the
// transfer. cfg writes are always taken.
module mersenne_twister_bounded_rng_top
  import mtb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mtb_req_if.sink   req,
  mtb_rsp_if.source rsp,
  mtb_cfg_if.sink   cfg
);
  logic [31:0] mem [N];
  logic [31:0] rd_data;
  logic [IDX_W-1:0] addr;
  logic we;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  state_t state, state_next;
  logic [31:0] seed;
  logic enable;
  logic pending;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] k;
  logic [31:0] prev;
  logic [31:0] w_k;
  logic [31:0] w_n;
  logic [31:0] prod;
  logic op_q;
  logic [31:0] bound_q;
  logic [31:0] out_val;
  logic out_valid;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [IDX_W-1:0] k_nxt, k_far;
  logic [31:0] y_mix, tw_new;
  logic need_seed;

  assign k_nxt = (k == IDX_W'(N - 1)) ? '0 : k + 1'b1;
  assign k_far = (k >= IDX_W'(N - M)) ? k - IDX_W'(N - M) : k + IDX_W'(M);
  assign y_mix = (w_k & 32'h80000000) | (w_n & 32'h7fffffff);
  assign tw_new = rd_data ^ (y_mix >> 1) ^ (y_mix[0] ? MATRIX : 32'd0);
  assign need_seed = pending || (rd_idx == IDX_NEVER);

  mtb_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.value = out_val;

  logic acc;
  assign acc = req.valid && req.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (req.op == OP_BOUNDED && (!enable || req.range_bound <= 32'd1)) begin
            state_next = ST_OUT;
          end else if (need_seed) begin
            state_next = ST_INIT_WR;
          end else if (rd_idx >= IDX_DUE) begin
            state_next = ST_TW_RD0;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_INIT_RD:  state_next = ST_INIT_MUL;
      ST_INIT_MUL: state_next = ST_INIT_WR;
      ST_INIT_WR:  state_next = (k == IDX_W'(N - 1)) ? ST_TW_RD0 : ST_INIT_RD;
      ST_TW_RD0:   state_next = ST_TW_RD1;
      ST_TW_RD1:   state_next = ST_TW_RD2;
      ST_TW_RD2:   state_next = ST_TW_WR;
      ST_TW_WR:    state_next = (k == IDX_W'(N - 1)) ? ST_RD : ST_TW_RD0;
      ST_RD:       state_next = ST_TEMPER;
      ST_TEMPER:   state_next = (op_q == OP_RAW) ? ST_OUT : ST_DIV;
      ST_DIV:      state_next = drsp.done ? ST_OUT : ST_DIV;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory port and divider control
  always_comb begin
    addr = k;
    we = 1'b0;
    wdata = prev;
    dreq.start = 1'b0;
    dreq.dividend = temper(rd_data);
    dreq.divisor = bound_q;
    unique case (state)
      ST_INIT_RD: addr = k;
      ST_INIT_WR: begin
        we = 1'b1;
        wdata = (k == '0) ? seed : prod + 32'(k);
      end
      ST_TW_RD0: addr = k;
      ST_TW_RD1: addr = k_nxt;
      ST_TW_RD2: addr = k_far;
      ST_TW_WR: begin
        we = 1'b1;
        wdata = tw_new;
      end
      ST_RD: addr = rd_idx;
      ST_TEMPER: dreq.start = (op_q == OP_BOUNDED);
      default: addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seed <= DEFAULT_SEED;
      enable <= 1'b0;
      pending <= 1'b0;
      rd_idx <= IDX_NEVER;
      out_valid <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        if (cfg.index == REG_SEED) begin
          seed <= cfg.data;
          pending <= 1'b1;
        end else begin
          enable <= cfg.data[0];
        end
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc && state_next == ST_INIT_WR) begin
            // default seed used only when never seeded and none pending
            if (!pending) begin
              seed <= DEFAULT_SEED;
            end
            pending <= 1'b0;
          end
          k <= '0;
        end
        ST_INIT_WR: begin
          k <= (k == IDX_W'(N - 1)) ? '0 : k + 1'b1;
        end
        ST_TW_WR: begin
          k <= k_nxt;
          if (k == IDX_W'(N - 1)) begin
            rd_idx <= '0;
          end
        end
        ST_RD: rd_idx <= rd_idx + 1'b1;
        ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_q <= req.op;
      bound_q <= req.range_bound;
      out_val <= '0;
    end
    if (state == ST_INIT_WR) begin
      prev <= wdata;
    end
    if (state == ST_INIT_RD) begin
      prod <= INIT_MULT * (prev ^ (prev >> 30));
    end
    if (state == ST_TW_RD1) begin
      w_k <= rd_data;
    end
    if (state == ST_TW_RD2) begin
      w_n <= rd_data;
    end
    if (state == ST_TEMPER) begin
      if (op_q == OP_RAW) begin
        out_val <= temper(rd_data);
      end
    end
    if (drsp.done) begin
      out_val <= drsp.rem;
    end
  end

  // assertions
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    acc |=> !req.ready) else $error("request taken while busy");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= IDX_NEVER) else $error("read index out of range");
  a_div_only: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == ST_DIV) else $error("stray divider result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.value))
    else $error("result dropped");
endmodule
